[hdl/twks_pkg.sv]
// Shared types, codes and constants of the timed window key sequencer.
package twks_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned WIN_W      = 3;
  localparam int unsigned NUM_KEYS   = 4;

  localparam logic [TICK_W-1:0] HOLD_TICKS  = 16'd50;
  localparam logic [7:0]        MAX_WINDOWS = 8'd4;
  localparam logic [TICK_W-1:0] TICK_SAT    = 16'hFFFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WINDOW_COUNT = 3'd0,
    REG_SWAP_DELAY   = 3'd1,
    REG_QUIET_TIME   = 3'd2,
    REG_FIRST_KEY    = 3'd3,
    REG_SECOND_KEY   = 3'd4,
    REG_THIRD_KEY    = 3'd5,
    REG_FOURTH_KEY   = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    STEP_WAIT_PRESS   = 2'd0,
    STEP_WAIT_RELEASE = 2'd1,
    STEP_WAIT_CYCLE   = 2'd2
  } step_t;

  typedef struct packed {
    logic [7:0]                        window_count;
    logic [TICK_W-1:0]                 swap_delay_ms;
    logic [TICK_W-1:0]                 quiet_after_input_ms;
    logic [NUM_KEYS-1:0][KEY_W-1:0]    keys;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       key_action;
    logic [KEY_W-1:0] key_code;
  } result_t;

endpackage

[hdl/twks_cfg.sv]
// Configuration register file of the timed window key sequencer.
module twks_cfg
  import twks_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_count         <= 8'd2;
      cfg_r.swap_delay_ms        <= 16'd1000;
      cfg_r.quiet_after_input_ms <= 16'd1000;
      cfg_r.keys[0]              <= 8'd49;
      cfg_r.keys[1]              <= 8'd50;
      cfg_r.keys[2]              <= 8'd51;
      cfg_r.keys[3]              <= 8'd52;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_WINDOW_COUNT: cfg_r.window_count         <= cfg_wdata[7:0];
        REG_SWAP_DELAY:   cfg_r.swap_delay_ms        <= cfg_wdata;
        REG_QUIET_TIME:   cfg_r.quiet_after_input_ms <= cfg_wdata;
        REG_FIRST_KEY:    cfg_r.keys[0]              <= cfg_wdata[KEY_W-1:0];
        REG_SECOND_KEY:   cfg_r.keys[1]              <= cfg_wdata[KEY_W-1:0];
        REG_THIRD_KEY:    cfg_r.keys[2]              <= cfg_wdata[KEY_W-1:0];
        REG_FOURTH_KEY:   cfg_r.keys[3]              <= cfg_wdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/twks_step.sv]
// Per-tick sequence state and step logic of the timed window key sequencer.
module twks_step
  import twks_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    tick_en,
  input  logic    host_message,
  input  logic    toggle_enable,
  input  cfg_t    cfg,
  output result_t result
);

  logic [1:0]        step_r,    step_nxt;
  logic [WIN_W-1:0]  win_r,     win_nxt;
  logic [TICK_W-1:0] tsa_r,     tsa_nxt;
  logic [TICK_W-1:0] tsh_r,     tsh_nxt;
  logic              enable_r,  enable_nxt;
  logic [TICK_W-1:0] tsa_inc;
  logic [WIN_W-1:0]  win_inc;
  logic              quiet;
  logic              count_ok;

  always_comb begin
    tsa_inc    = (tsa_r == TICK_SAT) ? TICK_SAT : tsa_r + 16'd1;
    tsh_nxt    = host_message ? '0 : ((tsh_r == TICK_SAT) ? TICK_SAT : tsh_r + 16'd1);
    enable_nxt = enable_r ^ toggle_enable;
    quiet      = (tsh_nxt < cfg.quiet_after_input_ms) || !enable_nxt;
    count_ok   = cfg.window_count inside {[8'd1:MAX_WINDOWS]};
    win_inc    = win_r + 3'd1;

    step_nxt          = step_r;
    win_nxt           = win_r;
    tsa_nxt           = tsa_inc;
    result.key_action = ACT_NONE;
    result.key_code   = '0;

    if (quiet) begin
      step_nxt          = STEP_WAIT_PRESS;
      win_nxt           = '0;
      tsa_nxt           = '0;
      result.key_action = ACT_RELEASE;
    end else if (count_ok) begin
      case (step_r)
        STEP_WAIT_PRESS: begin
          if (tsa_inc >= cfg.swap_delay_ms) begin
            result.key_action = ACT_PRESS;
            result.key_code   = cfg.keys[win_r[1:0]];
            tsa_nxt           = '0;
            step_nxt          = STEP_WAIT_RELEASE;
          end
        end
        STEP_WAIT_RELEASE: begin
          if (tsa_inc >= HOLD_TICKS) begin
            result.key_action = ACT_RELEASE;
            tsa_nxt           = '0;
            win_nxt           = win_inc;
            step_nxt          = ({5'd0, win_inc} < cfg.window_count) ? STEP_WAIT_PRESS
                                                                      : STEP_WAIT_CYCLE;
          end
        end
        default: begin
          if (tsa_inc >= cfg.swap_delay_ms) begin
            step_nxt = STEP_WAIT_PRESS;
            win_nxt  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_WAIT_PRESS;
      win_r    <= '0;
      tsa_r    <= '0;
      tsh_r    <= '0;
      enable_r <= 1'b0;
    end else if (tick_en) begin
      step_r   <= step_nxt;
      win_r    <= win_nxt;
      tsa_r    <= tsa_nxt;
      tsh_r    <= tsh_nxt;
      enable_r <= enable_nxt;
    end
  end

  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == STEP_WAIT_PRESS || step_r == STEP_WAIT_RELEASE || step_r == STEP_WAIT_CYCLE)
    else $error("sequence step left its legal codes");

  a_host_clears: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en && host_message |=> tsh_r == '0)
    else $error("host message did not restart the quiet period");

  a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en && !enable_nxt |=> step_r == STEP_WAIT_PRESS && win_r == '0 && tsa_r == '0)
    else $error("sequence not held at start while disabled");

endmodule

[hdl/twks_out.sv]
// Result register with skid stage of the timed window key sequencer.
module twks_out
  import twks_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  result_t          push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_key_action,
  output logic [KEY_W-1:0] out_key_code
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    pop;

  assign pop      = out_valid_r && out_ready;
  assign can_push = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (pop) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid_r || pop) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_key_action = out_data_r.key_action;
  assign out_key_code   = out_data_r.key_code;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage filled while result register empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    push && out_valid_r && !out_ready |=> skid_valid_r && out_valid_r)
    else $error("transfer lost while receiver stalled");

endmodule

[hdl/timed_window_key_sequencer.sv]
// Top level of the timed window key sequencer.
//
// One input transfer is one millisecond tick carrying in_host_message and
// in_toggle_enable. Each accepted tick yields exactly one result transfer on
// the out_ channel: out_key_action (none, press GUI plus key, release all)
// and out_key_code (the key pressed, zero otherwise).
// Each result is registered, in the result register or in the skid stage.
// Throughput: one tick per cycle while in_ready is high; the step logic
// updates the sequence state in the accepting cycle and the result goes
// to a result register. When the receiver stalls, a one-entry skid stage
// behind the result register takes one more tick; in_ready drops only
// while that stage is full and rises again on the cycle after the receiver
// takes a result. Configuration is written through cfg_we, cfg_addr and
// cfg_wdata, with no read-back; unknown indexes are ignored. Write only while
// no results are outstanding.
// Reset (rst_n low, synchronous) restores the register defaults, clears
// the sequence state and counters, disables the sequence and empties the
// result register and skid stage.
module timed_window_key_sequencer
  import twks_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_host_message,
  input  logic                  in_toggle_enable,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_key_action,
  output logic [KEY_W-1:0]      out_key_code,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  result_t result;
  logic    can_push;
  logic    tick_en;

  assign in_ready = can_push;
  assign tick_en  = in_valid && can_push;

  twks_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  twks_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_en       (tick_en),
    .host_message  (in_host_message),
    .toggle_enable (in_toggle_enable),
    .cfg           (cfg),
    .result        (result)
  );

  twks_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (tick_en),
    .push_data      (result),
    .can_push       (can_push),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_key_action (out_key_action),
    .out_key_code   (out_key_code)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench for the timed window key sequencer: directed tick table, random phases, checked by a predictor.
module tb;
  import twks_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_TICKS     = 40;
  localparam int N_PHASES       = 10;
  localparam int N_ROWS         = 24;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

  typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  host;
    logic                  tog;
    logic                  typed;
    action_t               act;
    logic [KEY_W-1:0]      code;
    logic [CFG_ADDR_W-1:0] idx;
    logic [CFG_DATA_W-1:0] val;
  } script_row_t;

  localparam script_row_t SCRIPT [N_ROWS] = '{
    '{ROW_TICK, 1'b0, 1'b0, 1'b1, ACT_RELEASE, 8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_TICK, 1'b1, 1'b1, 1'b1, ACT_RELEASE, 8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_QUIET_TIME,   16'h0000},
    '{ROW_TICK, 1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_TICK, 1'b0, 1'b0, 1'b1, ACT_NONE,    8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_WINDOW_COUNT, 16'h00FF},
    '{ROW_TICK, 1'b1, 1'b0, 1'b1, ACT_NONE,    8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_SWAP_DELAY,   16'h0000},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_FIRST_KEY,    16'hFFFF},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_SECOND_KEY,   16'hFF00},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_THIRD_KEY,    16'h00A5},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_FOURTH_KEY,   16'h005A},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_WINDOW_COUNT, 16'hFF04},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_UNUSED,       16'hFFFF},
    '{ROW_TICK, 1'b0, 1'b0, 1'b1, ACT_PRESS,   8'hFF, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_TICK, 1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_TICK, 1'b1, 1'b1, 1'b1, ACT_RELEASE, 8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_TICK, 1'b0, 1'b1, 1'b0, ACT_NONE,    8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_QUIET_TIME,   16'hFFFF},
    '{ROW_TICK, 1'b1, 1'b0, 1'b1, ACT_RELEASE, 8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_CFG,  1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_QUIET_TIME,   16'h0001},
    '{ROW_TICK, 1'b0, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_WINDOW_COUNT, 16'h0000},
    '{ROW_TICK, 1'b1, 1'b0, 1'b0, ACT_NONE,    8'h00, REG_WINDOW_COUNT, 16'h0000}
  };

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_host_message  = 1'b0;
  logic                  in_toggle_enable = 1'b0;
  logic                  out_ready        = 1'b0;
  logic                  cfg_we           = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr         = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata        = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic [1:0]            out_key_action;
  logic [KEY_W-1:0]      out_key_code;

  step_t             st_step       = STEP_WAIT_PRESS;
  logic [WIN_W-1:0]  st_win        = '0;
  logic [TICK_W-1:0] st_act_ticks  = '0;
  logic [TICK_W-1:0] st_host_ticks = '0;
  logic              st_enabled    = 1'b0;

  logic [7:0]        c_win_count = 8'd2;
  logic [TICK_W-1:0] c_swap      = 16'd1000;
  logic [TICK_W-1:0] c_quiet     = 16'd1000;
  logic [KEY_W-1:0]  c_keys [NUM_KEYS] = '{8'd49, 8'd50, 8'd51, 8'd52};

  result_t due_keys [$];
  int      mismatches  = 0;
  int      idle_cycles = 0;
  int      gap_odds    = 0;
  int      stall_odds  = 0;
  int      stall_left  = 0;

  timed_window_key_sequencer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_host_message  (in_host_message),
    .in_toggle_enable (in_toggle_enable),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_key_action   (out_key_action),
    .out_key_code     (out_key_code),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic result_t step_sequencer(input logic host, input logic tog);
    result_t r;
    r.key_action = ACT_NONE;
    r.key_code   = '0;
    if (st_act_ticks != TICK_SAT) st_act_ticks = st_act_ticks + 1'b1;
    if (st_host_ticks != TICK_SAT) st_host_ticks = st_host_ticks + 1'b1;
    if (host) st_host_ticks = '0;
    if (tog) st_enabled = ~st_enabled;
    if (st_host_ticks < c_quiet || !st_enabled) begin
      st_step      = STEP_WAIT_PRESS;
      st_win       = '0;
      st_act_ticks = '0;
      r.key_action = ACT_RELEASE;
    end else if (c_win_count >= 8'd1 && c_win_count <= MAX_WINDOWS) begin
      case (st_step)
        STEP_WAIT_PRESS: begin
          if (st_act_ticks >= c_swap) begin
            r.key_action = ACT_PRESS;
            r.key_code   = c_keys[st_win[1:0]];
            st_act_ticks = '0;
            st_step      = STEP_WAIT_RELEASE;
          end
        end
        STEP_WAIT_RELEASE: begin
          if (st_act_ticks >= HOLD_TICKS) begin
            r.key_action = ACT_RELEASE;
            st_act_ticks = '0;
            st_win       = st_win + 1'b1;
            st_step      = ({5'd0, st_win} < c_win_count) ? STEP_WAIT_PRESS : STEP_WAIT_CYCLE;
          end
        end
        default: begin
          if (st_act_ticks >= c_swap) begin
            st_step = STEP_WAIT_PRESS;
            st_win  = '0;
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_WINDOW_COUNT: c_win_count = val[7:0];
      REG_SWAP_DELAY:   c_swap      = val;
      REG_QUIET_TIME:   c_quiet     = val;
      REG_FIRST_KEY:    c_keys[0]   = val[KEY_W-1:0];
      REG_SECOND_KEY:   c_keys[1]   = val[KEY_W-1:0];
      REG_THIRD_KEY:    c_keys[2]   = val[KEY_W-1:0];
      REG_FOURTH_KEY:   c_keys[3]   = val[KEY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_tick(input logic host, input logic tog, input logic typed,
                           input result_t want);
    result_t predicted;
    cfg_we           <= 1'b0;
    in_valid         <= 1'b1;
    in_host_message  <= host;
    in_toggle_enable <= tog;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = step_sequencer(host, tog);
    due_keys.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained;
    in_valid <= 1'b0;
    while (due_keys.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Hold out_ready low in random bursts
  always @(posedge clk) begin
    if (stall_odds == 0) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t due;
    if (rst_n && out_valid && out_ready) begin
      if (due_keys.size() == 0) begin
        mismatches++;
        $error("result transfer with no tick pending: key_action %0d key_code %0d",
               out_key_action, out_key_code);
      end else begin
        due = due_keys.pop_front();
        if (out_key_action !== due.key_action) begin
          mismatches++;
          $error("key_action: expected %0d, actual %0d", due.key_action, out_key_action);
        end
        if (out_key_code !== due.key_code) begin
          mismatches++;
          $error("key_code: expected %0d, actual %0d", due.key_code, out_key_code);
        end
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    script_row_t row;
    row_kind_t   prev_kind;
    result_t     want;
    logic        host;
    logic        tog;
    int          n_items;
    int          pause_at;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_kind = ROW_TICK;
    for (int r = 0; r < N_ROWS; r++) begin
      row = SCRIPT[r];
      if (row.kind == ROW_CFG) begin
        if (prev_kind == ROW_TICK) wait_drained();
        write_reg(row.idx, row.val);
      end else begin
        want.key_action = row.act;
        want.key_code   = row.code;
        send_tick(row.host, row.tog, row.typed, want);
      end
      prev_kind = row.kind;
    end

    want = '0;
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      if ($urandom_range(0, 1) == 1)
        write_reg(REG_WINDOW_COUNT, ($urandom_range(0, 4) != 0) ?
                  16'($urandom_range(1, 4)) : 16'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1)
        write_reg(REG_SWAP_DELAY, ($urandom_range(0, 5) == 0) ?
                  16'd0 : 16'($urandom_range(1, 12)));
      if ($urandom_range(0, 1) == 1)
        write_reg(REG_QUIET_TIME, 16'($urandom_range(0, 30)));
      for (int k = 0; k < NUM_KEYS; k++)
        if ($urandom_range(0, 1) == 1)
          write_reg(CFG_ADDR_W'(REG_FIRST_KEY + k), 16'($urandom));
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 16'($urandom));

      case ($urandom_range(0, 2))
        0: gap_odds = 0;
        1: gap_odds = 10;
        default: gap_odds = 3;
      endcase
      case ($urandom_range(0, 2))
        0: stall_odds <= 0;
        1: stall_odds <= 10;
        default: stall_odds <= 3;
      endcase

      n_items  = $urandom_range(90, 170);
      pause_at = $urandom_range(0, n_items - 1);
      for (int i = 0; i < n_items; i++) begin
        if (i == pause_at) wait_drained();
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        host = ($urandom_range(0, 99) < 2);
        // mostly stay enabled, but drop out now and then
        tog = st_enabled ? ($urandom_range(0, 199) == 0) : ($urandom_range(0, 3) == 0);
        send_tick(host, tog, 1'b0, want);
      end
    end

    // Run the longest delays with no idling
    wait_drained();
    gap_odds = 0;
    stall_odds <= 0;
    write_reg(REG_WINDOW_COUNT, 16'd1);
    write_reg(REG_SWAP_DELAY, 16'hFFFF);
    write_reg(REG_QUIET_TIME, 16'hFFFF);
    write_reg(REG_FIRST_KEY, 16'($urandom));
    send_tick(1'b0, ~st_enabled, 1'b0, want);
    for (int i = 0; i < TAIL_TICKS; i++) send_tick(1'b0, 1'b0, 1'b0, want);

    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

[timed_window_key_sequencer.f]
hdl/twks_pkg.sv
hdl/twks_cfg.sv
hdl/twks_step.sv
hdl/twks_out.sv
hdl/timed_window_key_sequencer.sv
test/tb.sv
